// File: rtl/lmc_pkg.sv
// Shared types, constants and helper functions for the local minimum counter.
package lmc_pkg;

  localparam int READING_WIDTH   = 32;
  localparam int COUNT_WIDTH     = 21;
  localparam int REG_WIDTH       = 11;
  localparam int CFG_INDEX_WIDTH = 8;
  localparam int MAX_COLUMNS     = 1024;
  localparam int MAX_ROWS        = 1024;
  localparam int COL_WIDTH       = $clog2(MAX_COLUMNS);
  localparam int ROW_WIDTH       = $clog2(MAX_ROWS);

  typedef logic signed [READING_WIDTH-1:0] reading_t;
  typedef logic [READING_WIDTH-1:0]        key_t;
  typedef logic [COUNT_WIDTH-1:0]          count_t;
  typedef logic [REG_WIDTH-1:0]            reg_t;
  typedef logic [CFG_INDEX_WIDTH-1:0]      cfg_index_t;
  typedef logic [COL_WIDTH-1:0]            col_t;
  typedef logic [ROW_WIDTH-1:0]            row_t;

  // Register indexes of the configuration port.
  localparam cfg_index_t REG_ROW_COUNT    = cfg_index_t'(0);
  localparam cfg_index_t REG_COLUMN_COUNT = cfg_index_t'(1);

  // Flipping the sign bit turns two's complement order into unsigned order.
  localparam key_t SIGN_MASK = {1'b1, {(READING_WIDTH-1){1'b0}}};

  // One line buffer entry: the value of an element and its candidate flag.
  typedef struct packed {
    key_t key;
    logic flag;
  } line_entry_t;

  // Index of the last column for a programmed column count.
  function automatic col_t last_column(reg_t v);
    reg_t less_one;
    less_one = v - reg_t'(1);
    if (v == '0) begin
      return '0;
    end else if (v > reg_t'(MAX_COLUMNS)) begin
      return col_t'(MAX_COLUMNS - 1);
    end else begin
      return less_one[COL_WIDTH-1:0];
    end
  endfunction

  // Index of the last row for a programmed row count.
  function automatic row_t last_row(reg_t v);
    reg_t less_one;
    less_one = v - reg_t'(1);
    if (v == '0) begin
      return '0;
    end else if (v > reg_t'(MAX_ROWS)) begin
      return row_t'(MAX_ROWS - 1);
    end else begin
      return less_one[ROW_WIDTH-1:0];
    end
  endfunction

endpackage

// File: rtl/lmc_reading_if.sv
// Stream interface that carries one matrix reading per transaction.
interface lmc_reading_if;
  logic              valid;
  logic              ready;
  lmc_pkg::reading_t reading;

  modport source (output valid, output reading, input ready);
  modport sink   (input valid, input reading, output ready);
endinterface

// File: rtl/lmc_count_if.sv
// Stream interface that carries one minimum count per transaction.
interface lmc_count_if;
  logic            valid;
  logic            ready;
  lmc_pkg::count_t minimum_count;

  modport source (output valid, output minimum_count, input ready);
  modport sink   (input valid, input minimum_count, output ready);
endinterface

// File: rtl/lmc_cfg_if.sv
// Configuration write interface: register index and write data.
interface lmc_cfg_if;
  logic                valid;
  logic                ready;
  lmc_pkg::cfg_index_t index;
  lmc_pkg::reg_t       data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/lmc_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module lmc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // A read of the address being written returns the old contents.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: rtl/local_minimum_count.sv
// Top level of the streaming strict 4-neighbour local minimum counter.
//
//   Channel          Role    Payload                  Transaction
//   reading_stream   sink    reading (32b signed)     one matrix element, raster order
//   count_stream     source  minimum_count (21b)      one count after each frame's last element
//   config_write     sink    index (8b), data (11b)   register write, always ready
//
// One element is accepted every cycle while the result buffer has room; the rate is
// set by the single write port of the line buffer RAM, which takes one entry per element.
// The count passes through the compute stage and the result buffer before it is
// offered on count_stream after the last element of a frame is accepted.
// Reset clears positions, sizes (1 x 1), the count and the output buffer; the
// line buffer needs no clearing because each row is written before it is read.
// Input stalls only while the two-entry result buffer would otherwise overflow.
module local_minimum_count (
  input logic clk,
  input logic rst,
  lmc_reading_if.sink   reading_stream,
  lmc_count_if.source   count_stream,
  lmc_cfg_if.sink       config_write
);

  // Effective frame size, held as the index of the last row and column.
  lmc_pkg::row_t rows_last;
  lmc_pkg::col_t cols_last;

  // Position of the next element to be accepted.
  lmc_pkg::row_t row_index;
  lmc_pkg::col_t column_index;

  logic accept;
  logic cfg_write;
  logic cfg_known;

  // Compute stage: the element accepted in the previous cycle, whose upper
  // neighbour arrives from the RAM in this cycle.
  logic          s1_valid;
  lmc_pkg::key_t s1_key;
  lmc_pkg::col_t s1_col;
  logic          s1_first_col;
  logic          s1_last_col;
  logic          s1_first_row;
  logic          s1_last_row;

  // The element to the left. Its flag is provisional until the element to
  // its right has been compared; only then is it written to the line buffer.
  lmc_pkg::key_t left_key;
  logic          left_flag;

  // The last column of the previous row never enters the RAM: it has no
  // right neighbour, so its final entry is kept here instead.
  lmc_pkg::line_entry_t tail_entry;

  // Line buffer and the bypass for a read that meets a write to the same entry.
  logic                 line_wr_en;
  lmc_pkg::col_t        line_wr_addr;
  lmc_pkg::line_entry_t line_wr_data;
  lmc_pkg::line_entry_t line_rd_data;
  logic                 fwd_valid;
  lmc_pkg::line_entry_t fwd_entry;
  lmc_pkg::line_entry_t up_entry;

  // Per-element decisions.
  logic            lt_left;
  logic            gt_left;
  logic            lt_up;
  logic            gt_up;
  logic            flag;
  logic            left_final;
  logic            inc_left;
  logic            inc_up;
  logic            inc_self;
  logic            frame_end;
  lmc_pkg::count_t running_count;
  lmc_pkg::count_t count_sum;

  // Two-entry result buffer.
  logic [1:0]      occupancy;
  logic [1:0]      occupancy_next;
  logic [1:0]      write_slot;
  logic            push;
  logic            pop;
  lmc_pkg::count_t result_head;
  lmc_pkg::count_t result_tail;

  assign accept    = reading_stream.valid && reading_stream.ready;
  assign cfg_write = config_write.valid && config_write.ready;
  assign config_write.ready = 1'b1;

  always_comb begin
    case (config_write.index)
      lmc_pkg::REG_ROW_COUNT:    cfg_known = 1'b1;
      lmc_pkg::REG_COLUMN_COUNT: cfg_known = 1'b1;
      default:                   cfg_known = 1'b0;
    endcase
  end

  // Frame size registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      rows_last <= '0;
      cols_last <= '0;
    end else if (cfg_write) begin
      case (config_write.index)
        lmc_pkg::REG_ROW_COUNT:    rows_last <= lmc_pkg::last_row(config_write.data);
        lmc_pkg::REG_COLUMN_COUNT: cols_last <= lmc_pkg::last_column(config_write.data);
        default: ;
      endcase
    end
  end

  // Raster position; any register write restarts the frame.
  always_ff @(posedge clk) begin
    if (rst) begin
      row_index    <= '0;
      column_index <= '0;
    end else if (cfg_write && cfg_known) begin
      row_index    <= '0;
      column_index <= '0;
    end else if (accept) begin
      if (column_index == cols_last) begin
        column_index <= '0;
        if (row_index == rows_last) begin
          row_index <= '0;
        end else begin
          row_index <= row_index + lmc_pkg::row_t'(1);
        end
      end else begin
        column_index <= column_index + lmc_pkg::col_t'(1);
      end
    end
  end

  // Capture the accepted element into the compute stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_key       <= lmc_pkg::key_t'(reading_stream.reading) ^ lmc_pkg::SIGN_MASK;
      s1_col       <= column_index;
      s1_first_col <= (column_index == '0);
      s1_last_col  <= (column_index == cols_last);
      s1_first_row <= (row_index == '0);
      s1_last_row  <= (row_index == rows_last);
    end
  end

  // The final entry of the left element goes to the RAM once this element
  // has settled whether it is greater than its left neighbour.
  assign line_wr_en        = s1_valid && !s1_first_col;
  assign line_wr_addr      = s1_col - lmc_pkg::col_t'(1);
  assign line_wr_data.key  = left_key;
  assign line_wr_data.flag = left_final;

  lmc_ram #(
    .WIDTH ($bits(lmc_pkg::line_entry_t)),
    .DEPTH (lmc_pkg::MAX_COLUMNS)
  ) u_line_ram (
    .clk     (clk),
    .wr_en   (line_wr_en),
    .wr_addr (line_wr_addr),
    .wr_data (line_wr_data),
    .rd_en   (accept),
    .rd_addr (column_index),
    .rd_data (line_rd_data)
  );

  // With two columns, the first element of a row reads the entry that the
  // previous element is writing in the same cycle, so that data is bypassed.
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_valid <= 1'b0;
    end else begin
      fwd_valid <= accept && line_wr_en && (line_wr_addr == column_index);
    end
  end

  always_ff @(posedge clk) begin
    fwd_entry <= line_wr_data;
  end

  always_comb begin
    if (s1_last_col) begin
      up_entry = tail_entry;
    end else if (fwd_valid) begin
      up_entry = fwd_entry;
    end else begin
      up_entry = line_rd_data;
    end
  end

  // Neighbour comparisons on order-preserving unsigned keys.
  assign lt_left = s1_key < left_key;
  assign gt_left = s1_key > left_key;
  assign lt_up   = s1_key < up_entry.key;
  assign gt_up   = s1_key > up_entry.key;

  // This element stays a candidate while every neighbour seen so far is greater.
  assign flag       = (s1_first_col || lt_left) && (s1_first_row || lt_up);
  assign left_final = left_flag && gt_left;

  // On the bottom row the left element is confirmed by its right neighbour;
  // elsewhere the element above is confirmed by the one below it. The
  // bottom-right element has no later neighbour and confirms itself.
  assign inc_left  = !s1_first_col && s1_last_row && left_final;
  assign inc_up    = !s1_first_row && up_entry.flag && gt_up;
  assign inc_self  = s1_last_row && s1_last_col && flag;
  assign frame_end = s1_last_row && s1_last_col;

  assign count_sum = running_count + lmc_pkg::count_t'(inc_left)
                   + lmc_pkg::count_t'(inc_up) + lmc_pkg::count_t'(inc_self);

  always_ff @(posedge clk) begin
    if (rst) begin
      running_count <= '0;
      left_flag     <= 1'b0;
      left_key      <= '0;
    end else if (cfg_write && cfg_known) begin
      running_count <= '0;
    end else if (s1_valid) begin
      running_count <= frame_end ? '0 : count_sum;
      left_flag     <= flag;
      left_key      <= s1_key;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && s1_last_col) begin
      tail_entry.key  <= s1_key;
      tail_entry.flag <= flag;
    end
  end

  // Result buffer. Input is taken only when the buffer will have room for a
  // result produced by that element in the following cycle.
  assign push = s1_valid && frame_end;
  assign pop  = (occupancy != 2'd0) && count_stream.ready;

  assign occupancy_next = occupancy + {1'b0, push} - {1'b0, pop};
  assign write_slot     = occupancy - {1'b0, pop};
  assign reading_stream.ready = (occupancy_next < 2'd2);

  always_ff @(posedge clk) begin
    if (rst) begin
      occupancy <= '0;
    end else begin
      occupancy <= occupancy_next;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && (occupancy == 2'd2)) begin
      result_head <= result_tail;
    end
    if (push) begin
      if (write_slot == 2'd0) begin
        result_head <= count_sum;
      end else begin
        result_tail <= count_sum;
      end
    end
  end

  assign count_stream.valid         = (occupancy != 2'd0);
  assign count_stream.minimum_count = result_head;

endmodule

// File: dv/lmc_minima_scoreboard.sv
// Scoreboard package: frame minimum predictor and the queue of expected counts.
package lmc_minima_tb_pkg;
  import lmc_pkg::*;

  // A programmed size of zero behaves as one, and anything above the limit as the limit.
  function automatic int unsigned clamp_size(reg_t v, int unsigned limit);
    if (v == '0) begin
      return 1;
    end
    if (v > limit) begin
      return limit;
    end
    return 32'(v);
  endfunction

  class minima_scoreboard;
    key_t        above_key [MAX_COLUMNS];
    bit          above_flag [MAX_COLUMNS];
    key_t        left_key;
    bit          left_cand;
    int unsigned row_pos;
    int unsigned col_pos;
    count_t      minima_so_far;
    reg_t        rows_reg;
    reg_t        cols_reg;
    count_t      expected_counts [$];
    int unsigned mismatches;
    int unsigned counts_checked;
    int unsigned readings_seen;

    function new();
      left_key      = '0;
      left_cand     = 1'b0;
      row_pos       = 0;
      col_pos       = 0;
      minima_so_far = '0;
      rows_reg      = reg_t'(1);
      cols_reg      = reg_t'(1);
      mismatches    = 0;
      counts_checked = 0;
      readings_seen = 0;
    endfunction

    function int unsigned pending();
      return expected_counts.size();
    endfunction

    function void flag_mismatch(string what, count_t want, count_t got);
      mismatches++;
      if (mismatches <= 10) begin
        $display("[%0t] mismatch: %s, expected %0d, actual %0d", $time, what, want, got);
      end
    endfunction

    // A write to either size register restarts the frame; other indexes are ignored.
    function void apply_register(cfg_index_t idx, reg_t data);
      if (idx == REG_ROW_COUNT) begin
        rows_reg = data;
      end else if (idx == REG_COLUMN_COUNT) begin
        cols_reg = data;
      end else begin
        return;
      end
      row_pos       = 0;
      col_pos       = 0;
      minima_so_far = '0;
    endfunction

    // Advances the frame by one element and queues a count at the end of a frame.
    function void note_reading(reading_t value);
      key_t        key;
      int unsigned rows;
      int unsigned cols;
      int unsigned r;
      int unsigned c;
      bit          on_last_row;
      bit          on_last_col;
      bit          cand;
      key  = key_t'(value) ^ SIGN_MASK;
      rows = clamp_size(rows_reg, MAX_ROWS);
      cols = clamp_size(cols_reg, MAX_COLUMNS);
      r    = row_pos;
      c    = col_pos;
      on_last_row = (r + 1 >= rows);
      on_last_col = (c + 1 >= cols);
      cand = 1'b1;
      readings_seen++;
      if (c >= MAX_COLUMNS) begin
        c = MAX_COLUMNS - 1;
      end
      if (c > 0) begin
        if (!(key < left_key)) begin
          cand = 1'b0;
        end
        if (!(key > left_key)) begin
          left_cand         = 1'b0;
          above_flag[c - 1] = 1'b0;
        end
        // On the last row the left element has no lower neighbour, so it is settled now.
        if (on_last_row && left_cand) begin
          minima_so_far++;
        end
      end
      if (r > 0) begin
        if (!(key < above_key[c])) begin
          cand = 1'b0;
        end
        if (above_flag[c] && key > above_key[c]) begin
          minima_so_far++;
        end
      end
      above_key[c]  = key;
      above_flag[c] = cand;
      if (on_last_row && on_last_col && cand) begin
        minima_so_far++;
      end
      left_key  = key;
      left_cand = cand;
      if (!on_last_col) begin
        col_pos = c + 1;
        return;
      end
      col_pos = 0;
      if (!on_last_row) begin
        row_pos = r + 1;
        return;
      end
      expected_counts.push_back(minima_so_far);
      row_pos       = 0;
      minima_so_far = '0;
    endfunction

    function void check_count(count_t got);
      count_t want;
      if (expected_counts.size() == 0) begin
        flag_mismatch("count with no frame outstanding", '0, got);
        return;
      end
      want = expected_counts.pop_front();
      counts_checked++;
      if (got !== want) begin
        flag_mismatch("minimum_count", want, got);
      end
    endfunction
  endclass

endpackage

// File: dv/tb_local_minimum_count.sv
// Self-checking testbench for the streaming local minimum counter.
module tb_local_minimum_count;
  timeunit 1ns;
  timeprecision 1ps;

  import lmc_pkg::*;
  import lmc_minima_tb_pkg::*;

  // Roughly this many readings are sent in the random part of the run.
  localparam int unsigned RANDOM_READINGS = 200;
  // Cycles without any transaction before the run is declared hung. The longest
  // legitimate silence is the deliberate receiver hold-off, well below this.
  localparam int unsigned QUIET_LIMIT = 2000;
  // Margin left after every predicted count has been received, to let the pipeline run dry.
  localparam int unsigned SETTLE_CYCLES = 6;
  localparam int unsigned HOLD_OFF_CYCLES = 150;

  logic clk;
  logic rst;

  lmc_reading_if reading_stream();
  lmc_count_if   count_stream();
  lmc_cfg_if     config_write();

  local_minimum_count dut (
    .clk            (clk),
    .rst            (rst),
    .reading_stream (reading_stream),
    .count_stream   (count_stream),
    .config_write   (config_write)
  );

  minima_scoreboard minima_sb = new();

  // Shared control between the stimulus process and the receiver.
  bit          idle_on = 1'b1;
  int unsigned hold_request = 0;
  int unsigned quiet_cycles = 0;

  // Effective size of the frame currently programmed, as the stimulus sees it.
  int unsigned frame_rows = 1;
  int unsigned frame_cols = 1;
  int unsigned settings_used = 1;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Readings are mostly drawn from a narrow band so that ties and minima are common;
  // the rest are full-width values and values near the two ends of the range.
  function automatic reading_t pick_reading();
    case ($urandom_range(0, 9))
      0, 1: begin
        return reading_t'($urandom);
      end
      2: begin
        if ($urandom_range(0, 1) != 0) begin
          return reading_t'(32'h7fff_ffff - $urandom_range(0, 2));
        end
        return reading_t'(32'h8000_0000 + $urandom_range(0, 2));
      end
      default: begin
        return reading_t'(int'($urandom_range(0, 8)) - 4);
      end
    endcase
  endfunction

  // Offers one reading and returns at the edge where it is accepted, leaving valid
  // high so that a following call can present the next reading without a gap.
  task automatic send_reading(reading_t value);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      reading_stream.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    reading_stream.valid   <= 1'b1;
    reading_stream.reading <= value;
    @(posedge clk);
    while (!reading_stream.ready) begin
      @(posedge clk);
    end
  endtask

  // Stops the sender and waits until every predicted count has been received, then
  // lets the pipeline run dry. The first edge makes sure the final reading has been
  // recorded by the monitor before the outstanding count is looked at.
  task automatic settle();
    reading_stream.valid <= 1'b0;
    @(posedge clk);
    while (minima_sb.pending() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Leaves valid high on return; the caller lowers it once the last write has gone.
  task automatic write_register(cfg_index_t idx, reg_t value);
    config_write.valid <= 1'b1;
    config_write.index <= idx;
    config_write.data  <= value;
    @(posedge clk);
    while (!config_write.ready) begin
      @(posedge clk);
    end
  endtask

  task automatic configure(reg_t rows, reg_t cols);
    settle();
    write_register(REG_ROW_COUNT, rows);
    write_register(REG_COLUMN_COUNT, cols);
    config_write.valid <= 1'b0;
    frame_rows = clamp_size(rows, MAX_ROWS);
    frame_cols = clamp_size(cols, MAX_COLUMNS);
    settings_used++;
  endtask

  task automatic send_frames(int unsigned frames);
    repeat (frames) begin
      repeat (frame_rows * frame_cols) send_reading(pick_reading());
    end
  endtask

  // Receiver: random stall bursts while idling is enabled, and a long hold-off
  // whenever the stimulus asks for one. The hold-off is counted down here.
  initial begin
    int unsigned hold_left;
    int unsigned stall_left;
    hold_left  = 0;
    stall_left = 0;
    count_stream.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request != 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left != 0) begin
        count_stream.ready <= 1'b0;
        hold_left--;
      end else if (stall_left != 0) begin
        count_stream.ready <= 1'b0;
        stall_left--;
      end else if (idle_on && $urandom_range(0, 6) == 0) begin
        count_stream.ready <= 1'b0;
        stall_left = $urandom_range(1, 11) - 1;
      end else begin
        count_stream.ready <= 1'b1;
      end
    end
  end

  // Monitor: every transaction on any channel is seen here, at the edge where it
  // completes, and it also keeps the watchdog's count of silent cycles.
  always @(posedge clk) begin
    if (!rst) begin
      if (reading_stream.valid === 1'b1 && reading_stream.ready === 1'b1) begin
        minima_sb.note_reading(reading_stream.reading);
      end
      if (config_write.valid === 1'b1 && config_write.ready === 1'b1) begin
        minima_sb.apply_register(config_write.index, config_write.data);
      end
      if (count_stream.valid === 1'b1 && count_stream.ready === 1'b1) begin
        minima_sb.check_count(count_stream.minimum_count);
      end
    end
    if ((reading_stream.valid === 1'b1 && reading_stream.ready === 1'b1) ||
        (config_write.valid === 1'b1 && config_write.ready === 1'b1) ||
        (count_stream.valid === 1'b1 && count_stream.ready === 1'b1)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    while (quiet_cycles < QUIET_LIMIT) begin
      @(posedge clk);
    end
    $display("No transaction for %0d cycles, %0d counts still outstanding",
             QUIET_LIMIT, minima_sb.pending());
    $display("FAILURE");
    $finish;
  end

  initial begin
    int unsigned random_readings;
    int unsigned frame_len;
    reg_t        rows_pick;
    reg_t        cols_pick;
    random_readings = 0;

    rst                    <= 1'b1;
    reading_stream.valid   <= 1'b0;
    reading_stream.reading <= '0;
    config_write.valid     <= 1'b0;
    config_write.index     <= '0;
    config_write.data      <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part. After reset the frame is a single element, which is always a
    // minimum, so the extremes of the reading range each give a count of one.
    send_reading(reading_t'(32'h8000_0000));
    send_reading(reading_t'(32'h7fff_ffff));
    send_reading(reading_t'(0));
    send_reading(reading_t'(-1));
    send_reading(reading_t'(1));
    send_reading(reading_t'(32'h5555_5555));
    send_reading(reading_t'(32'haaaa_aaaa));

    // Zero sizes behave as one.
    configure(reg_t'(0), reg_t'(0));
    send_reading(reading_t'(-7));

    // A plateau with a single dip in the middle. Halfway through, a write to an
    // index that is not a register must leave the frame position alone.
    configure(reg_t'(3), reg_t'(3));
    send_reading(reading_t'(5));
    send_reading(reading_t'(5));
    send_reading(reading_t'(5));
    send_reading(reading_t'(5));
    settle();
    write_register(cfg_index_t'(200), reg_t'(3));
    config_write.valid <= 1'b0;
    send_reading(reading_t'(1));
    send_reading(reading_t'(5));
    send_reading(reading_t'(5));
    send_reading(reading_t'(5));
    send_reading(reading_t'(5));

    // Equal neighbours on the top row rule each other out; the two bottom corners
    // are minima with fewer neighbours.
    configure(reg_t'(2), reg_t'(3));
    send_reading(reading_t'(2));
    send_reading(reading_t'(2));
    send_reading(reading_t'(3));
    send_reading(reading_t'(-1));
    send_reading(reading_t'(4));
    send_reading(reading_t'(-1));

    // Back-pressure: the receiver holds off for a long stretch while short frames
    // keep arriving, so the result buffer fills and the input must stall. The
    // sender then waits for every count to come out before going on.
    configure(reg_t'(1), reg_t'(2));
    hold_request = HOLD_OFF_CYCLES;
    send_frames(12);
    settle();

    // Random part: small frames of random shape, mostly whole frames, sometimes a
    // frame cut short by the next register write, sometimes a pause to drain.
    while (random_readings < RANDOM_READINGS) begin
      idle_on = ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 9))
        0:       rows_pick = reg_t'(0);
        1:       rows_pick = reg_t'($urandom_range(7, 12));
        default: rows_pick = reg_t'($urandom_range(1, 6));
      endcase
      case ($urandom_range(0, 9))
        0:       cols_pick = reg_t'(0);
        1:       cols_pick = reg_t'($urandom_range(11, 16));
        default: cols_pick = reg_t'($urandom_range(1, 10));
      endcase
      configure(rows_pick, cols_pick);
      repeat ($urandom_range(1, 4)) begin
        frame_len = frame_rows * frame_cols;
        if ($urandom_range(0, 9) == 0) begin
          frame_len = $urandom_range(0, frame_len - 1);
        end
        repeat (frame_len) begin
          send_reading(pick_reading());
          random_readings++;
        end
        if ($urandom_range(0, 7) == 0) begin
          settle();
        end
      end
    end

    // Last part, with no idling on either side. Oversized row and column counts are
    // each applied to a frame that is left unfinished, so no count may appear, and a
    // whole mid-sized frame follows back to back.
    idle_on = 1'b0;
    configure(reg_t'(2047), reg_t'(2));
    repeat (30) send_reading(pick_reading());
    configure(reg_t'(2), reg_t'(2047));
    repeat (30) send_reading(pick_reading());
    configure(reg_t'(6), reg_t'(8));
    send_frames(1);

    settle();
    repeat (10) @(posedge clk);

    $display("Run covered %0d readings and %0d frame counts over %0d size settings,",
             minima_sb.readings_seen, minima_sb.counts_checked, settings_used);
    $display("from single elements to frames of 12 x 16, with oversized sizes; %0d mismatches.",
             minima_sb.mismatches);
    if (minima_sb.mismatches == 0 && minima_sb.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
